FILE: rtl/avam_pkg.sv
// avam_pkg: shared widths, codes and types for the volume atlas address map.
// Used by avam_div, volume_atlas_address_map and avam_checker.
package avam_pkg;

  localparam int COORD_BITS = 16;
  localparam int GRID_BITS  = 10;
  localparam int SLICE_BITS = 7;
  localparam int Z_BITS     = 6;
  localparam int MAX_SLICES = 64;
  localparam int CFG_IDX_BITS = 3;

  // one quotient bit per divider stage
  localparam int DIV_STAGES = COORD_BITS;
  // input register + divider + multiply stage + output register
  localparam int PIPE_LATENCY = DIV_STAGES + 3;

  // inverse slice index: (y / grid_height) * tile_columns + (x / grid_width)
  localparam int SLICE_SUM_BITS = COORD_BITS + SLICE_BITS + 1;

  typedef enum logic {
    FUNC_FWD = 1'b0,
    FUNC_INV = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GRID_WIDTH   = 3'd0,
    REG_GRID_HEIGHT  = 3'd1,
    REG_GRID_DEPTH   = 3'd2,
    REG_TILE_COLUMNS = 3'd3,
    REG_TILE_ROWS    = 3'd4,
    REG_ATLAS_WIDTH  = 3'd5,
    REG_ATLAS_HEIGHT = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    func_t                 func;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [Z_BITS-1:0]     z;
  } item_t;

endpackage

FILE: rtl/avam_div.sv
// avam_div: pipelined restoring divider, one quotient bit per register stage.
// Depends on avam_pkg for widths and stage count.
module avam_div import avam_pkg::*; (
  input  logic                  clk,
  input  logic [COORD_BITS-1:0] dividend,
  input  logic [GRID_BITS-1:0]  divisor,
  output logic [COORD_BITS-1:0] quotient,
  output logic [GRID_BITS-1:0]  remainder
);

  logic [COORD_BITS-1:0] num_r [DIV_STAGES];
  logic [GRID_BITS-1:0]  rem_r [DIV_STAGES];
  logic [GRID_BITS-1:0]  den_r [DIV_STAGES];

  logic [COORD_BITS-1:0] src_num [DIV_STAGES];
  logic [GRID_BITS-1:0]  src_rem [DIV_STAGES];
  logic [GRID_BITS-1:0]  src_den [DIV_STAGES];

  logic [COORD_BITS-1:0] num_next [DIV_STAGES];
  logic [GRID_BITS-1:0]  rem_next [DIV_STAGES];

  always_comb begin
    src_num[0] = dividend;
    src_rem[0] = '0;
    src_den[0] = divisor;
    for (int i = 1; i < DIV_STAGES; i++) begin
      src_num[i] = num_r[i-1];
      src_rem[i] = rem_r[i-1];
      src_den[i] = den_r[i-1];
    end
  end

  // num shifts the dividend out at the top and the quotient in at the bottom
  always_comb begin
    logic [GRID_BITS:0] trial;
    for (int i = 0; i < DIV_STAGES; i++) begin
      trial = {src_rem[i], src_num[i][COORD_BITS-1]};
      if (trial >= {1'b0, src_den[i]}) begin
        rem_next[i] = GRID_BITS'(trial - {1'b0, src_den[i]});
        num_next[i] = {src_num[i][COORD_BITS-2:0], 1'b1};
      end else begin
        rem_next[i] = trial[GRID_BITS-1:0];
        num_next[i] = {src_num[i][COORD_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      num_r[i] <= num_next[i];
      rem_r[i] <= rem_next[i];
      den_r[i] <= src_den[i];
    end
  end

  assign quotient  = num_r[DIV_STAGES-1];
  assign remainder = rem_r[DIV_STAGES-1];

endmodule

FILE: rtl/volume_atlas_address_map.sv
// volume_atlas_address_map: top level, maps volume cells to atlas texels and back.
// Depends on avam_pkg and avam_div.
//
// Usage:
//   Requests enter on start/func/coord_x/coord_y/coord_z; a transaction is
//   accepted at a clock edge with start high and busy low. busy stays low, so
//   one request can be accepted every cycle.
//   Each request yields one result on ok/out_x/out_y/out_z, marked by done for
//   exactly one cycle, after the input register, 16 divider stages, a multiply
//   stage and the output register. Results come out in request order. The
//   receiver cannot stall, so the pipeline never holds.
//   Throughput is one request per cycle; the bit-per-stage dividers compute
//   x / grid_width (or z / tile_columns) and y / grid_height.
//   Configuration is written over cfg_valid/cfg_ready/cfg_index/cfg_data
//   (cfg_ready is always high) while no request is in flight; indexes above
//   the last register are ignored.
//   Synchronous reset clears the configuration registers to zero and drops
//   every request in flight; no result strobes after reset until a new request
//   is accepted.
module volume_atlas_address_map import avam_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    func,
  input  logic [COORD_BITS-1:0]   coord_x,
  input  logic [COORD_BITS-1:0]   coord_y,
  input  logic [Z_BITS-1:0]       coord_z,
  output logic                    done,
  output logic                    ok,
  output logic [COORD_BITS-1:0]   out_x,
  output logic [COORD_BITS-1:0]   out_y,
  output logic [Z_BITS-1:0]       out_z,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_data
);

  logic [GRID_BITS-1:0]  grid_width;
  logic [GRID_BITS-1:0]  grid_height;
  logic [SLICE_BITS-1:0] grid_depth;
  logic [SLICE_BITS-1:0] tile_columns;
  logic [SLICE_BITS-1:0] tile_rows;
  logic [COORD_BITS-1:0] atlas_width;
  logic [COORD_BITS-1:0] atlas_height;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= '0;
      grid_height  <= '0;
      grid_depth   <= '0;
      tile_columns <= '0;
      tile_rows    <= '0;
      atlas_width  <= '0;
      atlas_height <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH:   grid_width   <= cfg_data[GRID_BITS-1:0];
        REG_GRID_HEIGHT:  grid_height  <= cfg_data[GRID_BITS-1:0];
        REG_GRID_DEPTH:   grid_depth   <= cfg_data[SLICE_BITS-1:0];
        REG_TILE_COLUMNS: tile_columns <= cfg_data[SLICE_BITS-1:0];
        REG_TILE_ROWS:    tile_rows    <= cfg_data[SLICE_BITS-1:0];
        REG_ATLAS_WIDTH:  atlas_width  <= cfg_data;
        REG_ATLAS_HEIGHT: atlas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- input register ----------------
  logic  in_valid;
  item_t in_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_item <= '{func: func_t'(func), x: coord_x, y: coord_y, z: coord_z};
  end

  // ---------------- dividers ----------------
  // divider A: x / grid_width for inverse, z / tile_columns for forward
  logic [COORD_BITS-1:0] div_a_num;
  logic [GRID_BITS-1:0]  div_a_den;
  logic [COORD_BITS-1:0] quo_a, quo_b;
  logic [GRID_BITS-1:0]  rem_a, rem_b;

  always_comb begin
    if (in_item.func == FUNC_INV) begin
      div_a_num = in_item.x;
      div_a_den = grid_width;
    end else begin
      div_a_num = COORD_BITS'(in_item.z);
      div_a_den = GRID_BITS'(tile_columns);
    end
  end

  avam_div u_div_a (
    .clk       (clk),
    .dividend  (div_a_num),
    .divisor   (div_a_den),
    .quotient  (quo_a),
    .remainder (rem_a)
  );

  avam_div u_div_b (
    .clk       (clk),
    .dividend  (in_item.y),
    .divisor   (grid_height),
    .quotient  (quo_b),
    .remainder (rem_b)
  );

  // item travels alongside the dividers
  logic  dly_valid [DIV_STAGES];
  item_t dly_item  [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_STAGES; i++) dly_valid[i] <= 1'b0;
    end else begin
      dly_valid[0] <= in_valid;
      for (int i = 1; i < DIV_STAGES; i++) dly_valid[i] <= dly_valid[i-1];
    end
  end

  always_ff @(posedge clk) begin
    dly_item[0] <= in_item;
    for (int i = 1; i < DIV_STAGES; i++) dly_item[i] <= dly_item[i-1];
  end

  // ---------------- multiply stage ----------------
  item_t d_item;
  assign d_item = dly_item[DIV_STAGES-1];

  logic                           m_valid;
  func_t                          m_func;
  logic                           m_rej;
  logic [COORD_BITS-1:0]          m_x, m_y;
  logic [Z_BITS+GRID_BITS-1:0]    m_px, m_py;
  logic [COORD_BITS+SLICE_BITS-1:0] m_ps;
  logic [COORD_BITS-1:0]          m_qa;
  logic [GRID_BITS-1:0]           m_ra, m_rb;

  logic fwd_rej, inv_rej;

  always_comb begin
    fwd_rej = (tile_columns == '0) || (tile_rows == '0) ||
              (d_item.x >= COORD_BITS'(grid_width)) ||
              (d_item.y >= COORD_BITS'(grid_height)) ||
              (SLICE_BITS'(d_item.z) >= grid_depth);
    inv_rej = (grid_width == '0) || (grid_height == '0) ||
              (tile_columns == '0) || (tile_rows == '0) ||
              (d_item.x >= atlas_width) || (d_item.y >= atlas_height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= dly_valid[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    m_func <= d_item.func;
    m_rej  <= (d_item.func == FUNC_INV) ? inv_rej : fwd_rej;
    m_x    <= d_item.x;
    m_y    <= d_item.y;
    // forward: z mod / div tile_columns both fit in Z_BITS
    m_px   <= Z_BITS'(rem_a) * grid_width;
    m_py   <= Z_BITS'(quo_a) * grid_height;
    m_ps   <= quo_b * tile_columns;
    m_qa   <= quo_a;
    m_ra   <= rem_a;
    m_rb   <= rem_b;
  end

  // ---------------- output stage ----------------
  logic [COORD_BITS:0]     tx, ty;
  logic [SLICE_SUM_BITS-1:0] slice;
  logic                    slice_bad;
  logic                    ok_next;
  logic [COORD_BITS-1:0]   x_next, y_next;
  logic [Z_BITS-1:0]       z_next;

  always_comb begin
    tx = (COORD_BITS+1)'(m_px) + (COORD_BITS+1)'(m_x);
    ty = (COORD_BITS+1)'(m_py) + (COORD_BITS+1)'(m_y);
    slice = SLICE_SUM_BITS'(m_ps) + SLICE_SUM_BITS'(m_qa);
    slice_bad = (slice >= SLICE_SUM_BITS'(grid_depth)) ||
                (slice >= SLICE_SUM_BITS'(MAX_SLICES));
    ok_next = 1'b0;
    x_next  = '0;
    y_next  = '0;
    z_next  = '0;
    if (m_func == FUNC_FWD) begin
      if (!m_rej) begin
        ok_next = (tx < (COORD_BITS+1)'(atlas_width)) &&
                  (ty < (COORD_BITS+1)'(atlas_height));
        x_next  = tx[COORD_BITS-1:0];
        y_next  = ty[COORD_BITS-1:0];
      end
    end else begin
      if (!m_rej && !slice_bad) begin
        ok_next = 1'b1;
        x_next  = COORD_BITS'(m_ra);
        y_next  = COORD_BITS'(m_rb);
        z_next  = slice[Z_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    ok    <= ok_next;
    out_x <= x_next;
    out_y <= y_next;
    out_z <= z_next;
  end

endmodule

FILE: rtl/avam_checker.sv
// avam_checker: port-level assertions for volume_atlas_address_map, bound below.
// Depends on avam_pkg for the pipeline latency.
module avam_checker import avam_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic                  ok,
  input logic [Z_BITS-1:0]     out_z,
  input logic                  cfg_ready
);

  // every accepted transaction produces its result a fixed time later
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LATENCY done)
    else $error("accepted request did not complete on time");

  // no result without a matching request
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result strobe without a request");

  // a rejected mapping never reports a slice
  a_reject_zero_z: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (out_z == '0))
    else $error("rejected result carries a slice");

  a_always_open: assert property (@(posedge clk) disable iff (rst)
    !busy && cfg_ready)
    else $error("block refused a transaction");

endmodule

bind volume_atlas_address_map avam_checker u_avam_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .ok        (ok),
  .out_z     (out_z),
  .cfg_ready (cfg_ready)
);
